[rtl/adsr_pkg.sv]
// ADSR envelope generator package: register indexes, constants, shaping helpers.
// No dependencies.
`timescale 1ns / 1ps
package adsr_pkg;
	localparam int unsigned MaxSegmentSamples = 1048575;
	localparam int unsigned RetriggerFadeSamples = 64;
	localparam int LenW = 20;
	localparam int PosW = 22;
	localparam int IncW = 25;
	localparam int CfgW = 20;
	localparam int IdxW = 3;

	localparam logic [IdxW-1:0] REG_ATTACK_LEN  = 3'd0;
	localparam logic [IdxW-1:0] REG_DECAY_LEN   = 3'd1;
	localparam logic [IdxW-1:0] REG_RELEASE_LEN = 3'd2;
	localparam logic [IdxW-1:0] REG_SUSTAIN     = 3'd3;
	localparam logic [IdxW-1:0] REG_ATTACK_SHP  = 3'd4;
	localparam logic [IdxW-1:0] REG_DECAY_SHP   = 3'd5;
	localparam logic [IdxW-1:0] REG_RELEASE_SHP = 3'd6;

	localparam logic [1:0] SHP_LINEAR = 2'd0;
	localparam logic [1:0] SHP_EXP    = 2'd1;

	localparam logic signed [47:0] One24   = 48'sh1000000;
	localparam logic signed [47:0] RampTop = 48'shFFFE00;
	localparam logic signed [47:0] LogGain = 48'sh5998;
	localparam logic signed [47:0] LogBias = 48'sh1A3D;
	localparam logic signed [47:0] Unity   = 48'sd32767;

	function automatic logic signed [47:0] floor_shr(input logic signed [47:0] v,
		input int n);
		floor_shr = v >>> n;
	endfunction

	function automatic logic signed [47:0] clamp_q15(input logic signed [47:0] v);
		if (v > Unity) clamp_q15 = Unity;
		else if (v < -Unity) clamp_q15 = -Unity;
		else clamp_q15 = v;
	endfunction
endpackage

[rtl/adsr_envelope_generator.sv]
// ADSR envelope generator top level: sequencer, shared multiplier and divider.
// Depends on adsr_pkg.
`timescale 1ns / 1ps
// Usage:
// Input channel (valid/ready) carries one sample tick: position and gate.
// Output channel (valid/ready) returns one level and is_idle per tick.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while idle, which the block does not enforce. Each request
// runs a small sequencer over one shared 26x26 multiplier and one radix-2
// restoring divider (48 steps, one a cycle). A note start runs two divisions,
// a release start one, and a logarithmic shape and an attack fade blend one
// each. One request at a time: ready is low from acceptance until the result
// has been taken, and the next request is taken in the cycle after that at the
// earliest.
// Reset: envelope idle, level 0, registers at their reset values.
// A stalled receiver holds the result; no new request is taken until it goes.
module adsr_envelope_generator
	import adsr_pkg::*;
#(
	parameter int unsigned MAX_SEGMENT_SAMPLES    = MaxSegmentSamples,
	parameter int unsigned RETRIGGER_FADE_SAMPLES = RetriggerFadeSamples
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [IdxW-1:0]         cfg_index,
	input  logic [CfgW-1:0]         cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PosW-1:0]         position,
	input  logic                    gate,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [15:0]      level,
	output logic                    is_idle
);
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_START = 10'b0000000010,
		ST_DIVA  = 10'b0000000100,
		ST_DIVD  = 10'b0000001000,
		ST_RAMP  = 10'b0000010000,
		ST_SHAPE = 10'b0000100000,
		ST_LOG   = 10'b0001000000,
		ST_FADE  = 10'b0010000000,
		ST_FIN   = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	typedef enum logic [2:0] {
		SEG_ATT, SEG_DEC, SEG_SUS, SEG_REL, SEG_REL_END, SEG_QUIET
	} seg_t;

	state_t state_q;
	seg_t   seg_q;

	logic [LenW-1:0] attack_len_q, decay_len_q, release_len_q;
	logic [14:0]     sustain_q;
	logic [1:0]      attack_shp_q, decay_shp_q, release_shp_q;

	logic idle_q, active_q;
	logic signed [15:0] prev_out_q, rel_from_q, fade_from_q, sus_lat_q;
	logic [PosW-1:0] prev_pos_q, pos_q;
	logic [LenW-1:0] lat_att_q, lat_dec_q, lat_rel_q;
	logic [IncW-1:0] att_inc_q, dec_inc_q, rel_inc_q;
	logic [1:0] shp_q;
	logic signed [47:0] ramp_q, l_q, val_q;

	// shared divider: 48-bit restoring, unsigned magnitudes
	logic [47:0] dnum_q, dquo_q, drem_q;
	logic [23:0] dden_q;
	logic [5:0]  dcnt_q;
	logic        dneg_q, dbusy_q;
	logic [48:0] rem_sh;
	assign rem_sh = {drem_q, dnum_q[47]};

	// shared multiplier; every operand fits in 26 signed bits
	logic signed [25:0] ma, mb;
	logic signed [47:0] mp;
	assign mp = 48'(ma * mb);

	function automatic logic [LenW-1:0] sat_len(input logic [CfgW-1:0] v);
		sat_len = (32'(v) > MAX_SEGMENT_SAMPLES) ? LenW'(MAX_SEGMENT_SAMPLES) : v[LenW-1:0];
	endfunction

	logic [LenW-1:0] fade_len;
	assign fade_len = (32'(lat_att_q) < RETRIGGER_FADE_SAMPLES) ? lat_att_q
		: LenW'(RETRIGGER_FADE_SAMPLES);

	logic [2:0] sub_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign is_idle = idle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q <= '0; decay_len_q <= '0; release_len_q <= '0;
			sustain_q <= 15'h7FFF;
			attack_shp_q <= '0; decay_shp_q <= '0; release_shp_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATTACK_LEN:  attack_len_q <= sat_len(cfg_data);
				REG_DECAY_LEN:   decay_len_q <= sat_len(cfg_data);
				REG_RELEASE_LEN: release_len_q <= sat_len(cfg_data);
				REG_SUSTAIN:     sustain_q <= cfg_data[14:0];
				REG_ATTACK_SHP:  attack_shp_q <= cfg_data[1:0];
				REG_DECAY_SHP:   decay_shp_q <= cfg_data[1:0];
				REG_RELEASE_SHP: release_shp_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// multiplier operand selection by state/substep
	always_comb begin
		ma = '0; mb = '0;
		unique case (state_q)
			ST_RAMP: begin
				ma = $signed({1'b0, seg_q == SEG_ATT ? att_inc_q :
					seg_q == SEG_DEC ? dec_inc_q : rel_inc_q});
				mb = $signed({4'd0, pos_q});
				if (seg_q == SEG_DEC) mb = $signed({4'd0, pos_q - PosW'(lat_att_q)});
			end
			ST_SHAPE: begin
				ma = 26'(l_q); mb = (shp_q == SHP_EXP) ? 26'(l_q) : 26'(LogGain);
			end
			ST_FIN: begin
				ma = 26'(l_q);
				unique case (seg_q)
					SEG_ATT: mb = 26'(Unity);
					SEG_DEC: mb = 26'(Unity - 48'(sus_lat_q));
					default: mb = 26'(48'(rel_from_q) * 2);
				endcase
			end
			ST_FADE: begin
				ma = 26'(l_q); mb = 26'(clamp_q15(val_q - 48'(fade_from_q)));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; seg_q <= SEG_QUIET;
			idle_q <= 1'b1; active_q <= 1'b0;
			prev_out_q <= '0; prev_pos_q <= '0;
			lat_att_q <= '0; lat_dec_q <= '0; lat_rel_q <= '0; sus_lat_q <= '0;
			att_inc_q <= '0; dec_inc_q <= '0; rel_inc_q <= '0;
			rel_from_q <= '0; fade_from_q <= '0;
			dbusy_q <= 1'b0; sub_q <= '0; level <= '0;
		end else begin
			// divider step
			if (dbusy_q) begin
				dnum_q <= {dnum_q[46:0], 1'b0};
				if (rem_sh >= {25'd0, dden_q}) begin
					drem_q <= 48'(rem_sh - {25'd0, dden_q});
					dquo_q <= {dquo_q[46:0], 1'b1};
				end else begin
					drem_q <= rem_sh[47:0];
					dquo_q <= {dquo_q[46:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == 6'd1) dbusy_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					pos_q <= position;
					if (!gate) begin
						if (idle_q) begin
							level <= '0; state_q <= ST_OUT; seg_q <= SEG_QUIET;
						end else if (active_q) begin
							lat_rel_q <= release_len_q; rel_from_q <= prev_out_q;
							active_q <= 1'b0; seg_q <= SEG_REL; shp_q <= release_shp_q;
							state_q <= ST_START;
						end else begin
							seg_q <= SEG_REL; shp_q <= release_shp_q; state_q <= ST_RAMP;
						end
					end else begin
						if (!active_q || position < prev_pos_q) begin
							lat_att_q <= attack_len_q; lat_dec_q <= decay_len_q;
							sus_lat_q <= {1'b0, sustain_q}; fade_from_q <= prev_out_q;
							idle_q <= 1'b0; active_q <= 1'b1; state_q <= ST_START;
						end else state_q <= ST_RAMP;
						prev_pos_q <= position;
						seg_q <= SEG_ATT;
					end
				end
				ST_START: begin
					// first divide: attack (or release) step
					dnum_q <= 48'(One24); drem_q <= '0; dquo_q <= '0;
					dden_q <= (seg_q == SEG_REL) ? 24'(lat_rel_q) : 24'(lat_att_q);
					dcnt_q <= 6'd48; dbusy_q <= 1'b1; state_q <= ST_DIVA;
				end
				ST_DIVA: if (!dbusy_q) begin
					if (seg_q == SEG_REL) begin
						rel_inc_q <= (lat_rel_q == '0) ? IncW'(One24) : dquo_q[IncW-1:0];
						state_q <= ST_RAMP;
					end else begin
						att_inc_q <= (lat_att_q == '0) ? IncW'(One24) : dquo_q[IncW-1:0];
						dnum_q <= 48'(One24); drem_q <= '0; dquo_q <= '0;
						dden_q <= 24'(lat_dec_q); dcnt_q <= 6'd48; dbusy_q <= 1'b1;
						state_q <= ST_DIVD;
					end
				end
				ST_DIVD: if (!dbusy_q) begin
					dec_inc_q <= (lat_dec_q == '0) ? IncW'(One24) : dquo_q[IncW-1:0];
					state_q <= ST_RAMP;
				end
				ST_RAMP: begin
					sub_q <= '0;
					if (seg_q == SEG_REL) begin
						if (pos_q < PosW'(lat_rel_q)) begin
							ramp_q <= RampTop - mp; state_q <= ST_SHAPE;
						end else begin
							level <= '0; prev_out_q <= '0; idle_q <= 1'b1;
							seg_q <= SEG_REL_END; state_q <= ST_OUT;
						end
					end else if (seg_q == SEG_DEC) begin
						// second pass: decay product now on the multiplier
						ramp_q <= RampTop - mp; state_q <= ST_SHAPE;
					end else if (pos_q < PosW'(lat_att_q)) begin
						ramp_q <= mp; shp_q <= attack_shp_q; state_q <= ST_SHAPE;
					end else if ({1'b0, pos_q} < 23'(lat_att_q) + 23'(lat_dec_q)) begin
						seg_q <= SEG_DEC; shp_q <= decay_shp_q;
					end else begin
						seg_q <= SEG_SUS; val_q <= 48'(sus_lat_q); state_q <= ST_FIN;
					end
				end
				ST_SHAPE: begin
					unique case (sub_q)
						3'd0: begin
							if (shp_q == SHP_LINEAR || shp_q == SHP_EXP)
								l_q <= 48'(signed'(ramp_q[24:9]));
							else l_q <= 48'(signed'(ramp_q[25:10]));
							sub_q <= 3'd1;
						end
						default: begin
							if (shp_q == SHP_LINEAR) begin
								state_q <= ST_FIN;
							end else if (shp_q == SHP_EXP) begin
								l_q <= 48'(signed'(mp[30:15]));
								state_q <= ST_FIN;
							end else begin
								// log: scaled / div, div = clamp(l + bias)
								val_q <= l_q + LogBias;
								ramp_q <= floor_shr(mp, 15) * 32768;
								state_q <= ST_LOG; sub_q <= '0;
							end
						end
					endcase
				end
				ST_LOG: begin
					if (sub_q == 3'd0) begin
						if (val_q == 0) begin
							l_q <= '0; state_q <= ST_FIN;
						end else begin
							dnum_q <= ramp_q[47] ? -ramp_q : ramp_q;
							dden_q <= (val_q > Unity - 1) ? 24'(Unity) :
								val_q[47] ? 24'(-val_q) : 24'(val_q);
							dneg_q <= ramp_q[47] ^ val_q[47];
							drem_q <= '0; dquo_q <= '0; dcnt_q <= 6'd48; dbusy_q <= 1'b1;
							sub_q <= 3'd1;
						end
					end else if (!dbusy_q) begin
						l_q <= 48'(signed'(16'((dneg_q ? -dquo_q : dquo_q) * 2)));
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					unique case (seg_q)
						SEG_ATT: begin
							val_q <= floor_shr(mp, 15);
							if (fade_len != '0 && pos_q < PosW'(fade_len)) begin
								dnum_q <= 48'(pos_q) * Unity; dden_q <= 24'(fade_len);
								drem_q <= '0; dquo_q <= '0; dcnt_q <= 6'd48; dbusy_q <= 1'b1;
								sub_q <= '0; state_q <= ST_FADE;
							end else begin
								level <= 16'(clamp_q15(floor_shr(mp, 15)));
								prev_out_q <= 16'(clamp_q15(floor_shr(mp, 15)));
								state_q <= ST_OUT;
							end
						end
						SEG_DEC: begin
							if (l_q[47]) begin
								level <= sus_lat_q; prev_out_q <= sus_lat_q;
							end else begin
								level <= 16'(clamp_q15(48'(sus_lat_q) + floor_shr(mp, 15)));
								prev_out_q <= 16'(clamp_q15(48'(sus_lat_q) + floor_shr(mp, 15)));
							end
							state_q <= ST_OUT;
						end
						SEG_SUS: begin
							level <= 16'(clamp_q15(val_q)); prev_out_q <= 16'(clamp_q15(val_q));
							state_q <= ST_OUT;
						end
						default: begin
							level <= mp[47] ? '0 : 16'(floor_shr(mp, 16));
							prev_out_q <= mp[47] ? '0 : 16'(floor_shr(mp, 16));
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_FADE: begin
					if (sub_q == 3'd0) begin
						if (!dbusy_q) begin
							l_q <= dquo_q; sub_q <= 3'd1;
						end
					end else begin
						level <= 16'(clamp_q15(48'(fade_from_q) + floor_shr(mp, 15)));
						prev_out_q <= 16'(clamp_q15(48'(fade_from_q) + floor_shr(mp, 15)));
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[rtl/adsr_checker.sv]
// Port-level checker for the ADSR envelope generator, bound to the top level.
// Depends on adsr_pkg.
`timescale 1ns / 1ps
module adsr_checker
	import adsr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [15:0] level,
	input logic is_idle
);
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after request");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while result pending");
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_idle |-> level == 16'sd0) else $error("idle with nonzero level");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level != 16'sh8000) else $error("level out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level)) else $error("result dropped");
endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .level(level), .is_idle(is_idle)
);

[tb/adsr_envelope_generator_tb.sv]
// Self-checking bench for adsr_envelope_generator: random notes, retriggers and releases
// against an in-bench envelope predictor. Depends on adsr_pkg and the block itself.
`timescale 1ns / 1ps
module adsr_envelope_generator_tb;
	import adsr_pkg::*;

	localparam longint RAMP_TOP  = 64'hFFFE00;
	localparam longint LOG_GAIN  = 64'h5998;
	localparam longint LOG_BIAS  = 64'h1A3D;
	localparam longint Q15_ONE   = 32767;
	localparam longint FADE_MAX  = 64;
	localparam longint CYCLE_CAP = 3000000;
	localparam int     SETTLE    = 400;
	localparam logic [IdxW-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [PosW-1:0] pos;
		logic            g;
	} tick_t;

	typedef struct packed {
		logic signed [15:0] lvl;
		logic               idle;
	} env_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PosW-1:0] position = '0;
	logic gate = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] level;
	logic is_idle;

	tick_t tick_q[$];
	env_t  env_q[$];
	int    errors = 0;
	int    levels_seen = 0;
	int    ticks_sent = 0;
	int    gap_left = 0;
	int    stall_left = 0;
	bit    calm = 1'b0;
	logic  hold_on = 1'b0;
	int    phase_no = 0;
	longint cycles = 0;

	// register copies
	longint c_att = 0, c_dec = 0, c_rel = 0, c_sus = 32767;
	logic [1:0] c_ashp = SHP_LINEAR, c_dshp = SHP_LINEAR, c_rshp = SHP_LINEAR;

	// envelope state
	bit     m_idle = 1'b1, m_active = 1'b0;
	longint m_prev_out = 0, m_prev_pos = 0;
	longint m_att = 0, m_dec = 0, m_rel = 0, m_sus = 0;
	longint m_att_inc = 0, m_dec_inc = 0, m_rel_inc = 0;
	longint m_rel_from = 0, m_fade_from = 0;

	adsr_envelope_generator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .position(position), .gate(gate),
		.out_valid(out_valid), .out_ready(out_ready), .level(level), .is_idle(is_idle)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint wrap16(longint v);
		logic signed [15:0] t;
		t = v[15:0];
		return longint'(t);
	endfunction

	function automatic longint sat_q15(longint v);
		if (v > Q15_ONE) return Q15_ONE;
		if (v < -Q15_ONE) return -Q15_ONE;
		return v;
	endfunction

	function automatic longint ramp_step(longint len);
		return len == 0 ? 64'h1000000 : 64'h1000000 / len;
	endfunction

	function automatic longint shape_curve(longint ramp, logic [1:0] kind);
		longint l, sq, dv, sc;
		if (kind == SHP_LINEAR) return wrap16(ramp >>> 9);
		if (kind == SHP_EXP) begin
			l = wrap16(ramp >>> 9);
			sq = (l * l * 2) & 64'hFFFFFFFF;
			return wrap16(sq >>> 16);
		end
		// codes two and three are logarithmic
		l = wrap16(ramp >>> 10);
		dv = l + LOG_BIAS;
		if (dv > Q15_ONE - 1) dv = Q15_ONE;
		if (dv == 0) return 0;
		sc = ((l * LOG_GAIN) >>> 15) * 32768;
		return wrap16((sc / dv) * 2);
	endfunction

	function automatic env_t envelope_next(tick_t t);
		env_t   r;
		longint p, v, l, fade, blend;
		p = t.pos;
		if (!t.g) begin
			if (m_idle) v = 0;
			else begin
				if (m_active) begin
					m_rel = c_rel;
					m_rel_from = m_prev_out;
					m_rel_inc = ramp_step(m_rel);
					m_active = 1'b0;
				end
				if (p < m_rel) begin
					l = shape_curve(RAMP_TOP - m_rel_inc * p, c_rshp);
					v = (l * m_rel_from * 2) >>> 16;
					if (v < 0) v = 0;
				end else begin
					v = 0;
					m_idle = 1'b1;
				end
				m_prev_out = v;
			end
		end else begin
			if (!m_active || p < m_prev_pos) begin
				m_att = c_att;
				m_dec = c_dec;
				m_sus = c_sus;
				m_fade_from = m_prev_out;
				m_att_inc = ramp_step(m_att);
				m_dec_inc = ramp_step(m_dec);
				m_idle = 1'b0;
				m_active = 1'b1;
			end
			m_prev_pos = p;
			fade = m_att < FADE_MAX ? m_att : FADE_MAX;
			if (p < m_att) begin
				v = (shape_curve(m_att_inc * p, c_ashp) * Q15_ONE) >>> 15;
				if (fade != 0 && p < fade) begin
					blend = (p * Q15_ONE) / fade;
					v = m_fade_from + ((blend * sat_q15(v - m_fade_from)) >>> 15);
				end
			end else if (p < m_att + m_dec) begin
				l = shape_curve(RAMP_TOP - m_dec_inc * (p - m_att), c_dshp);
				if (l < 0) l = 0;
				v = m_sus + ((l * (Q15_ONE - m_sus)) >>> 15);
			end else v = m_sus;
			v = sat_q15(v);
			m_prev_out = v;
		end
		r.lvl = v[15:0];
		r.idle = m_idle;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, levels_seen);
	endtask

	task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			REG_ATTACK_LEN:  c_att = d;
			REG_DECAY_LEN:   c_dec = d;
			REG_RELEASE_LEN: c_rel = d;
			REG_SUSTAIN:     c_sus = d[14:0];
			REG_ATTACK_SHP:  c_ashp = d[1:0];
			REG_DECAY_SHP:   c_dshp = d[1:0];
			REG_RELEASE_SHP: c_rshp = d[1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_tick(longint p, bit g);
		tick_t t;
		t.pos = p[PosW-1:0];
		t.g = g;
		tick_q.push_back(t);
	endtask

	// one held note with consecutive positions, maybe a retrigger, then a release
	task automatic push_note(int span);
		int hold, rel, rt;
		hold = $urandom_range(1, span);
		rel = $urandom_range(0, span);
		rt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, hold) : -1;
		for (int i = 0; i < hold; i++) begin
			push_tick(i, 1);
			if (i == rt)
				for (int k = 0; k < rt / 2 + 1; k++) push_tick(k, 1);
		end
		for (int i = 0; i < rel; i++) push_tick(i, 0);
	endtask

	task automatic push_noise();
		longint p;
		p = ($urandom_range(0, 1)) ? $urandom_range(0, 4194303) : $urandom_range(0, 300);
		push_tick(p, 1'($urandom_range(0, 1)));
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || in_valid || env_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			env_q.push_back(envelope_next({position, gate}));
			ticks_sent++;
		end
		if (!in_valid || in_ready) begin
			if (tick_q.size() != 0 && gap_left == 0 && arst_n) begin
				in_valid <= 1'b1;
				{position, gate} <= tick_q.pop_front();
				if (!calm)
					gap_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
						: $urandom_range(0, 2);
			end else begin
				in_valid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		env_t want;
		if (out_valid && out_ready) begin
			levels_seen++;
			if (env_q.size() == 0) begin
				report("unexpected result", level, 0);
			end else begin
				want = env_q.pop_front();
				if (level !== want.lvl) report("level", level, want.lvl);
				if (is_idle !== want.idle) report("is_idle", is_idle, want.idle);
			end
		end
		if (hold_on || !arst_n) out_ready <= 1'b0;
		else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 5) == 0)
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
					: $urandom_range(1, 3);
		end
	end

	// long receiver hold-off while ticks keep coming
	initial begin
		wait (phase_no == 4);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (3000) @(posedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int target;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: idle release, zero lengths, position extremes
		push_tick(0, 0);
		push_tick(4194303, 0);
		push_tick(0, 1);
		push_tick(1, 1);
		push_tick(4194303, 1);
		push_tick(5, 1);
		push_tick(0, 0);
		push_tick(0, 0);
		drain();
		write_reg(REG_UNUSED, 20'hFFFFF);
		write_reg(REG_ATTACK_LEN, 20'hFFFFF);
		write_reg(REG_DECAY_LEN, 20'hFFFFF);
		write_reg(REG_RELEASE_LEN, 20'hFFFFF);
		write_reg(REG_SUSTAIN, 20'h07FFF);
		write_reg(REG_ATTACK_SHP, 20'd3);
		write_reg(REG_DECAY_SHP, 20'd1);
		write_reg(REG_RELEASE_SHP, 20'd2);
		push_tick(0, 1);
		push_tick(1, 1);
		push_tick(63, 1);
		push_tick(4194303, 1);
		push_tick(1048575, 0);
		push_tick(3, 0);
		push_tick(0, 1);
		push_tick(2097151, 1);
		push_tick(0, 0);
		drain();
		write_reg(REG_SUSTAIN, 20'd0);
		write_reg(REG_ATTACK_LEN, 20'd1);
		write_reg(REG_DECAY_LEN, 20'd0);
		write_reg(REG_RELEASE_LEN, 20'd0);
		push_tick(0, 1);
		push_tick(1, 1);
		push_tick(0, 0);
		push_tick(0, 0);
		drain();

		for (int ph = 1; ph <= 12; ph++) begin
			phase_no = ph;
			calm = (ph % 5 == 0);
			write_reg(REG_ATTACK_LEN, (ph == 7) ? CfgW'($urandom_range(0, 1048575))
				: CfgW'($urandom_range(0, 80)));
			write_reg(REG_DECAY_LEN, (ph == 8) ? CfgW'(1048575) : CfgW'($urandom_range(0, 80)));
			write_reg(REG_RELEASE_LEN, (ph == 9) ? CfgW'($urandom_range(0, 1048575))
				: CfgW'($urandom_range(0, 80)));
			write_reg(REG_SUSTAIN, (ph == 2) ? CfgW'(0) : (ph == 3) ? CfgW'(32767)
				: CfgW'($urandom_range(0, 32767)));
			write_reg(REG_ATTACK_SHP, CfgW'(ph % 4));
			write_reg(REG_DECAY_SHP, CfgW'((ph / 4) % 4));
			write_reg(REG_RELEASE_SHP, CfgW'($urandom_range(0, 3)));
			target = tick_q.size() + 80;
			while (tick_q.size() < target) begin
				if ($urandom_range(0, 6) == 0) push_noise();
				else push_note(ph < 11 ? 50 : 100);
			end
			drain();
		end

		$display("covered %0d ticks over 12 register settings, all shapes, retriggers",
			ticks_sent);
		$display("and releases; %0d levels checked, %0d mismatches", levels_seen, errors);
		if (errors == 0 && env_q.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
